FILE: rtl/core/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, commands, S-box tables and GF(2^8) helpers for the AES core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ENCRYPT = 2'd1,
        CMD_DECRYPT = 2'd2,
        CMD_NONE    = 2'd3
    } command_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  key_index;
        logic [63:0] data_hi;
        logic [63:0] data_lo;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } out_item_t;

    typedef struct packed {
        logic first;
        logic last;
        logic inverse;
        logic mix_en;
    } round_ctl_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                r = r ^ p;
            end
            p = xtime(p);
        end
        gmul = r;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

endpackage

`default_nettype wire

FILE: rtl/core/aes_stream_if.sv
// ----------------------------------------------------------------------------
// AES stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface aes_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/aes_round_unit.sv
// ----------------------------------------------------------------------------
// AES round unit
// Shared combinational round: (Inv)ShiftRows, (Inv)SubBytes, (Inv)MixColumns,
// AddRoundKey with on-the-fly InvMixColumns of the key for decryption.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round_unit
(
    input  wire logic [127:0]      state_in,
    input  wire logic [127:0]      round_key,
    input  wire aes_pkg::round_ctl_t ctl,
    output logic      [127:0]      state_out
);

    logic [7:0] s   [16];
    logic [7:0] k   [16];
    logic [7:0] t   [16];
    logic [7:0] m   [16];
    logic [7:0] km  [16];
    logic [7:0] o   [16];

    function automatic logic [7:0] mixb(input logic [7:0] a0, input logic [7:0] a1,
                                        input logic [7:0] a2, input logic [7:0] a3,
                                        input logic inv);
        logic [7:0] r;
        if (inv)
        begin
            r = aes_pkg::gmul(a0, 4'd14) ^ aes_pkg::gmul(a1, 4'd11)
              ^ aes_pkg::gmul(a2, 4'd13) ^ aes_pkg::gmul(a3, 4'd9);
        end
        else
        begin
            r = aes_pkg::gmul(a0, 4'd2) ^ aes_pkg::gmul(a1, 4'd3) ^ a2 ^ a3;
        end
        mixb = r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8*i -: 8];
            k[i] = round_key[127 - 8*i -: 8];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (ctl.inverse)
                begin
                    t[r + 4*((c + r) % 4)] = aes_pkg::INV_SBOX[s[r + 4*c]];
                end
                else
                begin
                    t[r + 4*c] = aes_pkg::SBOX[s[r + 4*((c + r) % 4)]];
                end
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                m[4*c + j]  = mixb(t[4*c + j], t[4*c + (j+1)%4], t[4*c + (j+2)%4],
                                   t[4*c + (j+3)%4], ctl.inverse);
                km[4*c + j] = mixb(k[4*c + j], k[4*c + (j+1)%4], k[4*c + (j+2)%4],
                                   k[4*c + (j+3)%4], 1'b1);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (ctl.first)
            begin
                o[i] = s[i] ^ k[i];
            end
            else if (ctl.mix_en)
            begin
                o[i] = m[i] ^ (ctl.inverse ? km[i] : k[i]);
            end
            else
            begin
                o[i] = t[i] ^ k[i];
            end
            state_out[127 - 8*i -: 8] = o[i];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/aes_key_store.sv
// ----------------------------------------------------------------------------
// AES key store
// Round key memory, one 128-bit key per entry, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_store #(
    parameter int DEPTH = 15
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [127:0]             wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [127:0]             rd_data
);

    logic [127:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/aes_block_cipher_core.sv
// ----------------------------------------------------------------------------
// AES block cipher core
// Iterative AES-128/192/256 cipher with a loadable round key store.
//
// Channels: in_ch takes commands (load key, encrypt, decrypt) with a 128-bit
// block or key; out_ch returns one 128-bit block per encrypt or decrypt.
// A load gives no transaction on out_ch.
// An encrypt or decrypt reads the first key in the acceptance cycle, then
// makes one shared round unit pass for the initial AddRoundKey and one pass
// per round, and then gives a valid result on out_ch. in_ch.ready is low
// while a block is in work and while a result waits on out_ch.
// When out_ch stalls the result holds in the output register and no new
// transaction is taken until it leaves.
// Reset clears the sequencer and sets rounds to 10; the key store keeps no
// reset value and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher_core #(
    parameter int MAX_ROUNDS = 14
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata,
    aes_stream_if.sink      in_ch,
    aes_stream_if.source    out_ch
);

    localparam int DEPTH = MAX_ROUNDS + 1;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t       state_reg;
    logic [3:0]   rounds_reg;
    logic [3:0]   nr;
    logic         inv_reg;
    logic         first_reg;
    logic [3:0]   step_reg;
    logic [AW-1:0] key_addr;
    logic [127:0] blk_reg;
    logic [127:0] rd_data;
    logic [127:0] round_out;
    logic         accept;
    logic         wr_en;
    aes_pkg::round_ctl_t ctl;

    always_comb
    begin
        if (rounds_reg == 4'd0)
        begin
            nr = 4'd1;
        end
        else if (rounds_reg > 4'(MAX_ROUNDS))
        begin
            nr = 4'(MAX_ROUNDS);
        end
        else
        begin
            nr = rounds_reg;
        end
    end

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign wr_en = accept && (in_ch.payload.command == aes_pkg::CMD_LOAD)
                   && (in_ch.payload.key_index <= 4'(MAX_ROUNDS));

    // address the key for the next pass
    always_comb
    begin
        logic [3:0] idx;
        logic       is_dec;
        if (state_reg == ST_IDLE)
        begin
            idx    = 4'd0;
            is_dec = (in_ch.payload.command == aes_pkg::CMD_DECRYPT);
        end
        else
        begin
            idx    = first_reg ? 4'd1 : step_reg + 4'd2;
            is_dec = inv_reg;
        end
        key_addr = AW'(is_dec ? (nr - idx) : idx);
    end

    aes_key_store #(.DEPTH(DEPTH)) u_keys (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_ch.payload.key_index)),
        .wr_data ({in_ch.payload.data_hi, in_ch.payload.data_lo}),
        .rd_addr (key_addr),
        .rd_data (rd_data)
    );

    assign ctl.first   = first_reg;
    assign ctl.last    = !first_reg && (step_reg == nr - 4'd1);
    assign ctl.inverse = inv_reg;
    assign ctl.mix_en  = !first_reg && (step_reg != nr - 4'd1);

    aes_round_unit u_round (
        .state_in  (blk_reg),
        .round_key (rd_data),
        .ctl       (ctl),
        .state_out (round_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rounds_reg <= 4'd10;
            first_reg  <= 1'b0;
            inv_reg    <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rounds_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (in_ch.payload.command == aes_pkg::CMD_ENCRYPT
                                   || in_ch.payload.command == aes_pkg::CMD_DECRYPT))
                    begin
                        state_reg <= ST_RUN;
                        first_reg <= 1'b1;
                        step_reg  <= '0;
                        inv_reg   <= (in_ch.payload.command == aes_pkg::CMD_DECRYPT);
                    end
                end
                ST_RUN:
                begin
                    first_reg <= 1'b0;
                    if (!first_reg)
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                    if (!first_reg && step_reg == nr - 4'd1)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // step_reg is the index of the key applied this cycle minus one after the
    // first pass; the final pass happens when step_reg + 1 == nr
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg <= {in_ch.payload.data_hi, in_ch.payload.data_lo};
        end
        else if (state_reg == ST_RUN)
        begin
            blk_reg <= round_out;
        end
    end

    assign out_ch.valid             = (state_reg == ST_OUT);
    assign out_ch.payload.result_hi = blk_reg[127:64];
    assign out_ch.payload.result_lo = blk_reg[63:0];

endmodule

`default_nettype wire
